// ===== design/fmc_pkg.sv =====
// Package with the format constants shared by the minifloat converter.
package fmc_pkg;

    // Small float layout: sign at bit 15, exponent above mantissa.
    localparam int MAN_BITS   = 6;
    localparam int EXP_BITS   = 5;
    localparam int SMALL_BIAS = (1 << (EXP_BITS - 1)) - 1;
    localparam int DROP_BITS  = 23 - MAN_BITS;
    localparam int EXP_ONES   = (1 << EXP_BITS) - 1;

    // Conversion directions.
    localparam logic MODE_NARROW = 1'b0;
    localparam logic MODE_WIDEN  = 1'b1;

    // Input item held in the input register.
    typedef struct packed {
        logic        mode;
        logic [31:0] wide_bits;
        logic [15:0] narrow_bits;
    } fmc_item_t;

endpackage

// ===== design/float32_minifloat_convert_unit.sv =====
// Top level of the float32 and small float converter.
// Usage:
// The input channel (in_valid, in_stall) carries one item: mode, wide_bits and
// narrow_bits. Mode 0 narrows wide_bits to a small float word returned in the
// low 16 bits of converted_bits; mode 1 widens narrow_bits to a float32 word.
// The output channel (out_valid, out_stall) returns one item per input item,
// in order. An accepted item sits in the input register, passes one level of
// conversion logic and lands in the result register, where out_valid is set;
// a stall of the receiver can hold the item in the input register first.
// Throughput is one item per cycle while the receiver does not stall, set by
// the two-register pipeline with no loop. When the receiver stalls, the result
// register holds its item and the input register fills; in_stall rises only
// when both are full and the receiver stalls.
// Reset clears both valid flags; no item is held after reset.
module float32_minifloat_convert_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] wide_bits,
    input  logic [15:0] narrow_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] converted_bits
);
    import fmc_pkg::*;

    fmc_item_t   item_reg;
    logic        item_valid_reg;
    logic [31:0] res_reg;
    logic        res_valid_reg;
    logic [15:0] narrow_word;
    logic [31:0] wide_word;
    logic [31:0] res_next;
    logic        res_load;
    logic        in_take;

    // Conversion logic between the two registers.
    fmc_narrow u_narrow (.wide_bits(item_reg.wide_bits), .narrow_word(narrow_word));
    fmc_widen  u_widen  (.narrow_bits(item_reg.narrow_bits), .wide_word(wide_word));

    always_comb
    begin
        unique case (item_reg.mode)
            MODE_NARROW: res_next = {16'd0, narrow_word};
            MODE_WIDEN:  res_next = wide_word;
            default:     res_next = wide_word;
        endcase
    end

    // Pipeline control: each stage moves when the next one is free.
    assign res_load  = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !res_load;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= in_take || (item_valid_reg && !res_load);
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= '{mode: mode, wide_bits: wide_bits, narrow_bits: narrow_bits};
        if (res_load)
            res_reg <= res_next;
    end

    assign out_valid      = res_valid_reg;
    assign converted_bits = res_reg;

    // A held result must not be replaced while the receiver stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(converted_bits))
        else $error("result changed under stall");

    // Input stalls only while both stages are full.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg && res_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    // A narrowed result never has upper bits set.
    a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && item_reg.mode == MODE_NARROW |=> converted_bits[31:16] == 16'd0)
        else $error("narrow result has upper bits");

endmodule

// ===== design/fmc_narrow.sv =====
// Combinational float32 to small float narrowing with round to nearest even.
module fmc_narrow (
    input  logic [31:0] wide_bits,
    output logic [15:0] narrow_word
);
    import fmc_pkg::*;

    localparam logic [31:0] EXP_FIELD = 32'(EXP_ONES) << MAN_BITS;
    localparam logic [31:0] MAN_FIELD = (32'd1 << MAN_BITS) - 32'd1;
    localparam logic [31:0] HALF      = 32'd1 << (DROP_BITS - 1);

    logic [31:0] sgn;
    logic [7:0]  e8;
    logic [22:0] m23;
    logic signed [9:0] ne;
    logic signed [9:0] ne_rnd;
    logic [31:0] nm;
    logic [31:0] rest;
    logic        round_up;
    logic [31:0] nm_rnd;
    logic [31:0] result;

    // Field split and rounding decision.
    always_comb
    begin
        sgn      = {16'd0, wide_bits[31], 15'd0};
        e8       = wide_bits[30:23];
        m23      = wide_bits[22:0];
        ne       = $signed({2'b00, e8}) - 10'sd127 + 10'(SMALL_BIAS);
        nm       = 32'(m23 >> DROP_BITS);
        rest     = 32'(m23) & ((32'd1 << DROP_BITS) - 32'd1);
        round_up = (rest > HALF) || ((rest == HALF) && nm[0]);
        nm_rnd   = nm + 32'(round_up);
        ne_rnd   = ne;
        // A mantissa carry out bumps the exponent.
        if (nm_rnd > MAN_FIELD)
        begin
            nm_rnd = 32'd0;
            ne_rnd = ne + 10'sd1;
        end
    end

    // Special cases take priority over the normal path.
    always_comb
    begin
        priority if (e8 == 8'hFF)
            result = (m23 != 23'd0) ? (EXP_FIELD | 32'd1) : (sgn | EXP_FIELD);
        else if (e8 == 8'd0 && m23 == 23'd0)
            result = sgn;
        else if (ne >= 10'(EXP_ONES))
            result = sgn | EXP_FIELD;
        else if (ne <= 10'sd0)
            result = sgn;
        else if (ne_rnd >= 10'(EXP_ONES))
            result = sgn | EXP_FIELD;
        else
            result = sgn | (32'(ne_rnd[8:0]) << MAN_BITS) | nm_rnd;
    end

    assign narrow_word = result[15:0];

endmodule

// ===== design/fmc_widen.sv =====
// Combinational small float to float32 widening.
module fmc_widen (
    input  logic [15:0] narrow_bits,
    output logic [31:0] wide_word
);
    import fmc_pkg::*;

    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] m;
    logic [31:0] sgn;
    logic [31:0] fe;

    // Decode the fields and rebias the exponent.
    always_comb
    begin
        d   = 32'(narrow_bits);
        e   = (d >> MAN_BITS) & 32'(EXP_ONES);
        m   = d & ((32'd1 << MAN_BITS) - 32'd1);
        sgn = {narrow_bits[15], 31'd0};
        fe  = e - 32'(SMALL_BIAS) + 32'd127;
        priority if (e == 32'(EXP_ONES))
            wide_word = (m == 32'd0) ? (sgn | 32'h7F80_0000) : 32'h7FC0_0000;
        else if (e == 32'd0 && m == 32'd0)
            wide_word = sgn;
        else
            wide_word = sgn | ({24'd0, fe[7:0]} << 23) | (m << DROP_BITS);
    end

endmodule

// ===== test/tb_float32_minifloat_convert_unit.sv =====
// Testbench for the float32 and small float converter: directed table, then random items.
module tb_float32_minifloat_convert_unit;
    import fmc_pkg::*;

    localparam int RAND_ITEMS = 2000;
    localparam int CALM_ITEMS = 200;

    localparam logic [31:0] NAR_EXP_FIELD = 32'(EXP_ONES) << MAN_BITS;
    localparam logic [31:0] NAR_MAN_FIELD = (32'd1 << MAN_BITS) - 1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [31:0] wide_bits;
    logic [15:0] narrow_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] converted_bits;

    logic [31:0] pending_words[$];
    int          error_count;
    bit          feeding_done;
    bit          calm;

    float32_minifloat_convert_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .wide_bits(wide_bits), .narrow_bits(narrow_bits),
        .out_valid(out_valid), .out_stall(out_stall), .converted_bits(converted_bits)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Narrow a float32 pattern to the small word with round to nearest, ties to even.
    function automatic logic [31:0] narrow_word(logic [31:0] u);
        logic [31:0] sgn;
        logic [7:0]  e8;
        logic [22:0] m23;
        int          ne;
        logic [31:0] nm;
        logic [31:0] rest;
        logic [31:0] half;
        sgn = {16'd0, u[31], 15'd0};
        e8  = u[30:23];
        m23 = u[22:0];
        if (e8 == 8'hFF)
        begin
            if (m23 != 0)
                return (NAR_EXP_FIELD | 32'd1) & 32'hFFFF;
            return (sgn | NAR_EXP_FIELD) & 32'hFFFF;
        end
        if (e8 == 0 && m23 == 0)
            return sgn;
        ne = int'(e8) - 127 + SMALL_BIAS;
        if (ne >= EXP_ONES)
            return (sgn | NAR_EXP_FIELD) & 32'hFFFF;
        if (ne <= 0)
            return sgn;
        nm   = 32'(m23) >> DROP_BITS;
        rest = 32'(m23) & ((32'd1 << DROP_BITS) - 1);
        half = 32'd1 << (DROP_BITS - 1);
        if (rest > half || (rest == half && nm[0]))
        begin
            nm++;
            if (nm > NAR_MAN_FIELD)
            begin
                nm = 32'd0;
                ne++;
                if (ne >= EXP_ONES)
                    return (sgn | NAR_EXP_FIELD) & 32'hFFFF;
            end
        end
        return (sgn | (32'(ne) << MAN_BITS) | nm) & 32'hFFFF;
    endfunction

    // Widen a small word to a float32 pattern.
    function automatic logic [31:0] widen_word(logic [15:0] d);
        logic [31:0] e;
        logic [31:0] m;
        logic [31:0] sgn;
        logic [31:0] fe;
        e   = (32'(d) & NAR_EXP_FIELD) >> MAN_BITS;
        m   = 32'(d) & NAR_MAN_FIELD;
        sgn = {d[15], 31'd0};
        if (e == EXP_ONES)
        begin
            if (m == 0)
                return sgn | 32'h7F80_0000;
            return 32'h7FC0_0000;
        end
        if (e == 0 && m == 0)
            return sgn;
        fe = e - SMALL_BIAS + 127;
        return sgn | ((fe & 32'hFF) << 23) | (m << DROP_BITS);
    endfunction

    function automatic logic [31:0] convert_word(logic md, logic [31:0] w, logic [15:0] n);
        return (md == MODE_NARROW) ? narrow_word(w) : widen_word(n);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Present one item, then hold it until it is accepted.
    task automatic send_item(logic md, logic [31:0] w, logic [15:0] n, logic [31:0] want);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= md;
        wide_bits   <= w;
        narrow_bits <= n;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_words.push_back(want);
    endtask

    // Random float32 pattern biased toward exponents near the small range and rounding ties.
    function automatic logic [31:0] random_wide();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0, 1: w[30:23] = 8'(127 - SMALL_BIAS + $urandom_range(0, EXP_ONES + 1) - 1);
            2:
            begin
                w[30:23] = 8'(127 - SMALL_BIAS + $urandom_range(1, EXP_ONES - 1));
                w[DROP_BITS-1:0] = DROP_BITS'(1) << (DROP_BITS - 1);
            end
            3: w[30:23] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            default: ;
        endcase
        return w;
    endfunction

    // Stimulus: reset, directed table, then random items.
    initial
    begin
        typedef struct {
            logic        md;
            logic [31:0] w;
            logic [15:0] n;
            bit          typed;
            logic [31:0] want;
        } row_t;
        row_t        rows[$];
        logic [31:0] want;
        logic        md;
        logic [31:0] w;
        logic [15:0] n;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_NARROW;
        wide_bits    = '0;
        narrow_bits  = '0;
        error_count  = 0;
        feeding_done = 1'b0;
        calm         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{MODE_NARROW, 32'h0000_0000, 16'h0000, 1, 32'h0000_0000},
            '{MODE_NARROW, 32'h8000_0000, 16'hFFFF, 1, 32'h0000_8000},
            '{MODE_NARROW, 32'h7F80_0000, 16'h0000, 1, NAR_EXP_FIELD},
            '{MODE_NARROW, 32'hFF80_0000, 16'h0000, 1, 32'h8000 | NAR_EXP_FIELD},
            '{MODE_NARROW, 32'hFFFF_FFFF, 16'h0000, 1, NAR_EXP_FIELD | 1},
            '{MODE_NARROW, 32'h7F80_0001, 16'h0000, 1, NAR_EXP_FIELD | 1},
            '{MODE_NARROW, 32'h7F7F_FFFF, 16'h0000, 1, NAR_EXP_FIELD},
            '{MODE_NARROW, 32'h0000_0001, 16'h0000, 1, 32'h0000_0000},
            '{MODE_NARROW, 32'h807F_FFFF, 16'h0000, 1, 32'h0000_8000},
            '{MODE_NARROW, 32'h3F80_0000, 16'h0000, 0, 0},
            '{MODE_NARROW, 32'h3FFF_FFFF, 16'h0000, 0, 0},
            '{MODE_NARROW, 32'h3F82_0000, 16'h0000, 0, 0},
            '{MODE_NARROW, 32'h3F86_0000, 16'h0000, 0, 0},
            '{MODE_NARROW, 32'h477F_F000, 16'h0000, 0, 0},
            '{MODE_NARROW, 32'h3880_0000, 16'h0000, 0, 0},
            '{MODE_WIDEN,  32'hFFFF_FFFF, 16'h0000, 1, 32'h0000_0000},
            '{MODE_WIDEN,  32'h0000_0000, 16'h8000, 1, 32'h8000_0000},
            '{MODE_WIDEN,  32'h0000_0000, 16'(NAR_EXP_FIELD), 1, 32'h7F80_0000},
            '{MODE_WIDEN,  32'h0000_0000, 16'(32'h8000 | NAR_EXP_FIELD), 1, 32'hFF80_0000},
            '{MODE_WIDEN,  32'h0000_0000, 16'hFFFF, 1, 32'h7FC0_0000},
            '{MODE_WIDEN,  32'h0000_0000, 16'h0001, 0, 0},
            '{MODE_WIDEN,  32'h0000_0000, 16'h7FBF, 0, 0},
            '{MODE_WIDEN,  32'h0000_0000, 16'h3C2A, 0, 0}
        };
        foreach (rows[i])
        begin
            want = rows[i].typed ? rows[i].want
                                 : convert_word(rows[i].md, rows[i].w, rows[i].n);
            send_item(rows[i].md, rows[i].w, rows[i].n, want);
        end

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == RAND_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            md = 1'($urandom_range(0, 1));
            w  = random_wide();
            n  = 16'($urandom);
            send_item(md, w, n, convert_word(md, w, n));
        end
        in_valid <= 1'b0;
        feeding_done = 1'b1;
    end

    // Receiver: random stall bursts, compare against the oldest expected word.
    initial
    begin
        int burst;
        out_stall = 1'b0;
        burst     = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                    report_mismatch("unexpected item", converted_bits, 32'hx);
                else
                begin
                    logic [31:0] want;
                    want = pending_words.pop_front();
                    if (converted_bits !== want)
                        report_mismatch("converted_bits", converted_bits, want);
                end
            end
            if (burst > 0)
                burst--;
            else if (!calm && $urandom_range(0, 4) == 0)
                burst = $urandom_range(1, 6);
            out_stall <= (burst > 0);
        end
    end

    // End of run once every expected word has come back.
    initial
    begin
        wait (feeding_done);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fmc_pkg.sv
design/fmc_narrow.sv
design/fmc_widen.sv
design/float32_minifloat_convert_unit.sv
test/tb_float32_minifloat_convert_unit.sv
